[hdl/arb_pkg.sv]
// Package for the audio ring buffer device: buffer geometry, item kinds,
// register indexes and the decoded command that passes from front to back.
// No dependencies.
package arb_pkg;

	localparam int BUF_BYTES = 65536;
	localparam int BUF_AW    = $clog2(BUF_BYTES);

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_BUFWR = 2'd2;
	localparam logic [1:0] KIND_PULL  = 2'd3;

	localparam logic [2:0] RIDX_RATE     = 3'd0;
	localparam logic [2:0] RIDX_CHANNELS = 3'd1;
	localparam logic [2:0] RIDX_SAMPLES  = 3'd2;
	localparam logic [2:0] RIDX_BUFSIZE  = 3'd3;
	localparam logic [2:0] RIDX_INIT     = 3'd4;
	localparam logic [2:0] RIDX_COUNT    = 3'd5;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_RD    = 3'd1,
		OP_WR    = 3'd2,
		OP_BUFWR = 3'd3,
		OP_PULL  = 3'd4
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [2:0]        idx;
		logic [31:0]       data;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        sbyte;
	} cmd_t;

endpackage

[hdl/arb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module arb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/arb_front.sv]
// Front end: accepts items, classifies them into commands and queues them.
// Depends on arb_pkg.
module arb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    kind,
	input  logic [2:0]    reg_index,
	input  logic [31:0]   write_data,
	input  logic [15:0]   buffer_addr,
	input  logic [7:0]    buffer_byte,
	output arb_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          pop
);
	import arb_pkg::*;

	cmd_t            entry_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QAW:0]    cnt_q;
	cmd_t            dec;
	logic [31:0]     addr_ext;
	logic            push;
	logic            do_pop;

	assign addr_ext = 32'(buffer_addr);

	always_comb begin
		dec       = '0;
		dec.op    = OP_NOP;
		dec.idx   = reg_index;
		dec.data  = write_data;
		dec.addr  = addr_ext[BUF_AW-1:0];
		dec.sbyte = buffer_byte;
		case (kind)
			KIND_READ: dec.op = OP_RD;
			KIND_WRITE: begin
				if (reg_index inside {[RIDX_RATE:RIDX_COUNT]}) begin
					dec.op = OP_WR;
				end
			end
			KIND_BUFWR: begin
				if (addr_ext < 32'(BUF_BYTES)) begin
					dec.op = OP_BUFWR;
				end
			end
			KIND_PULL: dec.op = OP_PULL;
			default: dec.op = OP_NOP;
		endcase
	end

	assign busy      = (cnt_q == (QAW+1)'(QDEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != '0);
	assign do_pop    = pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hdl/arb_back.sv]
// Back end: executes queued commands on the registers and the sample RAM.
// Depends on arb_pkg and arb_ram.
module arb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  arb_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          pop,
	output logic          done,
	output logic [31:0]   read_data,
	output logic [7:0]    sample_byte,
	output logic          sample_valid
);
	import arb_pkg::*;

	logic [31:0]       rate_q;
	logic [31:0]       channels_q;
	logic [31:0]       samples_q;
	logic [31:0]       init_q;
	logic [31:0]       count_q;
	logic              started_q;
	logic [BUF_AW-1:0] rd_pos_q;

	logic              done_s2;
	logic              pull_ok_s2;
	logic [31:0]       rdata_s2;

	logic [31:0]       reg_rd;
	logic [31:0]       init_n;
	logic [31:0]       count_n;
	logic              pull_ok;
	logic              ram_we;
	logic [7:0]        ram_rdata;

	assign pop     = cmd_valid;
	assign pull_ok = cmd_valid && (cmd.op == OP_PULL) && started_q && (count_q != '0);
	assign ram_we  = cmd_valid && (cmd.op == OP_BUFWR);

	always_comb begin
		case (cmd.idx)
			RIDX_RATE:     reg_rd = rate_q;
			RIDX_CHANNELS: reg_rd = channels_q;
			RIDX_SAMPLES:  reg_rd = samples_q;
			RIDX_BUFSIZE:  reg_rd = started_q ? 32'(BUF_BYTES) : '0;
			RIDX_INIT:     reg_rd = init_q;
			RIDX_COUNT:    reg_rd = count_q;
			default:       reg_rd = '0;
		endcase
	end

	assign init_n  = (cmd.idx == RIDX_INIT) ? cmd.data : init_q;
	assign count_n = (cmd.idx == RIDX_COUNT) ? cmd.data : count_q;

	arb_ram #(
		.WIDTH (8),
		.DEPTH (BUF_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.addr),
		.wdata (cmd.sbyte),
		.raddr (rd_pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= '0;
			channels_q <= '0;
			samples_q  <= '0;
			init_q     <= '0;
			count_q    <= '0;
			started_q  <= 1'b0;
			rd_pos_q   <= '0;
			done_s2    <= 1'b0;
			pull_ok_s2 <= 1'b0;
			rdata_s2   <= '0;
		end else begin
			done_s2    <= cmd_valid;
			pull_ok_s2 <= pull_ok;
			rdata_s2   <= (cmd_valid && cmd.op == OP_RD) ? reg_rd : '0;
			if (cmd_valid && cmd.op == OP_WR) begin
				case (cmd.idx)
					RIDX_RATE:     rate_q     <= cmd.data;
					RIDX_CHANNELS: channels_q <= cmd.data;
					RIDX_SAMPLES:  samples_q  <= cmd.data;
					default:       rate_q     <= rate_q;
				endcase
				if (init_n == 32'd1) begin
					init_q    <= '0;
					count_q   <= '0;
					started_q <= 1'b1;
				end else begin
					init_q  <= init_n;
					count_q <= count_n;
				end
			end
			if (pull_ok) begin
				count_q  <= count_q - 32'd1;
				rd_pos_q <= (rd_pos_q == BUF_AW'(BUF_BYTES - 1)) ? '0 : rd_pos_q + 1'b1;
			end
		end
	end

	assign done         = done_s2;
	assign read_data    = rdata_s2;
	assign sample_byte  = pull_ok_s2 ? ram_rdata : '0;
	assign sample_valid = pull_ok_s2;

endmodule

[hdl/audio_ring_buffer_device.sv]
// Audio ring buffer device: register bank, sample ring and playback pulls.
// Each item gives its result on done from the back end's output registers.
// Throughput: one item per cycle; the back end retires one queued command per
// cycle, so busy stays low. Reset (arst_n low) clears all registers, count,
// the started flag and the read position; sample RAM contents stay undefined.
module audio_ring_buffer_device (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [2:0]  reg_index,
	input  logic [31:0] write_data,
	input  logic [15:0] buffer_addr,
	input  logic [7:0]  buffer_byte,
	output logic        done,
	output logic [31:0] read_data,
	output logic [7:0]  sample_byte,
	output logic        sample_valid
);
	import arb_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic pop;

	arb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.reg_index   (reg_index),
		.write_data  (write_data),
		.buffer_addr (buffer_addr),
		.buffer_byte (buffer_byte),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.pop         (pop)
	);

	arb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.pop          (pop),
		.done         (done),
		.read_data    (read_data),
		.sample_byte  (sample_byte),
		.sample_valid (sample_valid)
	);

endmodule

[hdl/arb_checker.sv]
// Port-level checker for the audio ring buffer device, bound to the top level.
// Depends on audio_ring_buffer_device.
module arb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] read_data,
	input logic [7:0]  sample_byte,
	input logic        sample_valid
);

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item gave no result after two cycles");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted item");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised although back end drains every cycle");

	a_pull_excl: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> (done && read_data == '0))
		else $error("sample_valid outside a pull result");

	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !sample_valid) |-> (sample_byte == '0))
		else $error("nonzero sample byte on silence");

endmodule

bind audio_ring_buffer_device arb_checker u_arb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.read_data    (read_data),
	.sample_byte  (sample_byte),
	.sample_valid (sample_valid)
);

[verif/tb_audio_ring_buffer_device.sv]
// Self-checking testbench for audio_ring_buffer_device: bus and playback items
// go in through start/busy and each done result is checked against a predictor.
// Depends on arb_pkg (kinds, register indexes, buffer geometry) and the RTL top.
module tb_audio_ring_buffer_device;
	import arb_pkg::*;

	localparam logic [2:0] RIDX_SPARE6 = 3'd6;
	localparam logic [2:0] RIDX_SPARE7 = 3'd7;
	localparam int N_RANDOM = 1450;

	typedef struct {
		logic [31:0]       rate;
		logic [31:0]       channels;
		logic [31:0]       samples;
		logic [31:0]       init;
		logic [31:0]       count;
		bit                started;
		logic [BUF_AW-1:0] rd_pos;
	} dev_state_t;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  idx;
		logic [31:0] wdata;
		logic [15:0] addr;
		logic [7:0]  bval;
		int unsigned idle_pct;
		bit          drain;
	} bus_item_t;

	typedef struct {
		logic [31:0] read_data;
		logic [7:0]  sample_byte;
		logic        sample_valid;
	} dev_response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  kind = KIND_READ;
	logic [2:0]  reg_index = RIDX_RATE;
	logic [31:0] write_data = '0;
	logic [15:0] buffer_addr = '0;
	logic [7:0]  buffer_byte = '0;
	logic        busy;
	logic        done;
	logic [31:0] read_data;
	logic [7:0]  sample_byte;
	logic        sample_valid;

	bus_item_t     bus_items[$];
	dev_response_t expected_responses[$];
	dev_state_t    live_state = '{default: '0};
	dev_state_t    plan_state = '{default: '0};
	logic [7:0]    ring_mem[BUF_BYTES];
	bit            ring_loaded[BUF_BYTES];
	int unsigned   cur_idle_pct = 11;
	bit            drain_next = 1'b0;
	int            items_sent = 0;
	int            results_seen = 0;
	int            fail_count = 0;

	audio_ring_buffer_device u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.buffer_addr  (buffer_addr),
		.buffer_byte  (buffer_byte),
		.done         (done),
		.read_data    (read_data),
		.sample_byte  (sample_byte),
		.sample_valid (sample_valid)
	);

	always #4 clk = ~clk;

	function automatic dev_response_t predict_response(inout dev_state_t st,
			input bus_item_t it, input logic [7:0] head);
		dev_response_t r;
		r = '{read_data: '0, sample_byte: '0, sample_valid: 1'b0};
		case (it.kind)
			KIND_READ: begin
				case (it.idx)
					RIDX_RATE:     r.read_data = st.rate;
					RIDX_CHANNELS: r.read_data = st.channels;
					RIDX_SAMPLES:  r.read_data = st.samples;
					RIDX_BUFSIZE:  r.read_data = st.started ? 32'(BUF_BYTES) : '0;
					RIDX_INIT:     r.read_data = st.init;
					RIDX_COUNT:    r.read_data = st.count;
					default:       r.read_data = '0;
				endcase
			end
			KIND_WRITE: begin
				if (it.idx <= RIDX_COUNT) begin
					case (it.idx)
						RIDX_RATE:     st.rate = it.wdata;
						RIDX_CHANNELS: st.channels = it.wdata;
						RIDX_SAMPLES:  st.samples = it.wdata;
						RIDX_INIT:     st.init = it.wdata;
						RIDX_COUNT:    st.count = it.wdata;
						default:       ;
					endcase
					if (st.init == 32'd1) begin
						st.count = '0;
						st.started = 1'b1;
						st.init = '0;
					end
				end
			end
			KIND_PULL: begin
				if (st.started && st.count != '0) begin
					r.sample_byte = head;
					r.sample_valid = 1'b1;
					st.rd_pos = BUF_AW'((int'(st.rd_pos) + 1) % BUF_BYTES);
					st.count = st.count - 32'd1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Load the byte at the read position first if a pull would fetch an unwritten entry.
	task automatic queue_item(logic [1:0] k, logic [2:0] idx, logic [31:0] wd,
			logic [15:0] ad, logic [7:0] bv);
		bus_item_t it;
		if (k == KIND_PULL && plan_state.started && plan_state.count != '0 &&
				!ring_loaded[plan_state.rd_pos])
			queue_item(KIND_BUFWR, idx, wd, 16'(plan_state.rd_pos), 8'($urandom));
		it = '{kind: k, idx: idx, wdata: wd, addr: ad, bval: bv,
			idle_pct: cur_idle_pct, drain: drain_next};
		drain_next = 1'b0;
		if (k == KIND_BUFWR && int'(ad) < BUF_BYTES)
			ring_loaded[ad] = 1'b1;
		void'(predict_response(plan_state, it, 8'h00));
		bus_items.push_back(it);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		bus_item_t     cur;
		bus_item_t     nxt;
		dev_response_t resp;
		logic [7:0]    head;
		bit            accepted;
		bit            nxt_start;
		int            sent_now;
		if (!arst_n) begin
			start <= 1'b0;
			kind <= KIND_READ;
			reg_index <= RIDX_RATE;
			write_data <= '0;
			buffer_addr <= '0;
			buffer_byte <= '0;
			items_sent <= 0;
		end else begin
			accepted = start && !busy;
			sent_now = items_sent + (accepted ? 1 : 0);
			if (accepted) begin
				cur = '{kind: kind, idx: reg_index, wdata: write_data, addr: buffer_addr,
					bval: buffer_byte, idle_pct: 0, drain: 1'b0};
				head = ring_mem[live_state.rd_pos];
				resp = predict_response(live_state, cur, head);
				if (cur.kind == KIND_BUFWR && int'(cur.addr) < BUF_BYTES)
					ring_mem[cur.addr] = cur.bval;
				expected_responses.push_back(resp);
			end
			items_sent <= sent_now;
			nxt_start = start && !accepted;
			if (!nxt_start && bus_items.size() != 0) begin
				nxt = bus_items[0];
				if (!(nxt.drain && sent_now != results_seen) &&
						$urandom_range(99) >= nxt.idle_pct) begin
					void'(bus_items.pop_front());
					kind <= nxt.kind;
					reg_index <= nxt.idx;
					write_data <= nxt.wdata;
					buffer_addr <= nxt.addr;
					buffer_byte <= nxt.bval;
					nxt_start = 1'b1;
				end
			end
			start <= nxt_start;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		dev_response_t e;
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done) begin
			if (expected_responses.size() == 0) begin
				$error("result with no item pending: read_data %h sample_byte %h sample_valid %b",
					read_data, sample_byte, sample_valid);
				fail_count++;
			end else begin
				e = expected_responses.pop_front();
				if (read_data !== e.read_data) begin
					$error("read_data: expected %h, got %h", e.read_data, read_data);
					fail_count++;
				end
				if (sample_byte !== e.sample_byte) begin
					$error("sample_byte: expected %h, got %h", e.sample_byte, sample_byte);
					fail_count++;
				end
				if (sample_valid !== e.sample_valid) begin
					$error("sample_valid: expected %b, got %b", e.sample_valid, sample_valid);
					fail_count++;
				end
			end
			results_seen <= results_seen + 1;
		end
	end

	initial begin : run_ctrl
		int          base;
		int          n;
		int          extra;
		logic [31:0] wd;
		base = 0;
		cur_idle_pct = 11;

		queue_item(KIND_READ, RIDX_BUFSIZE, '0, '0, '0);
		queue_item(KIND_PULL, RIDX_RATE, '0, '0, '0);
		queue_item(KIND_WRITE, RIDX_RATE, '1, 16'hFFFF, 8'hFF);
		queue_item(KIND_WRITE, RIDX_CHANNELS, '0, '0, '0);
		queue_item(KIND_WRITE, RIDX_SAMPLES, 32'hA5A5_A5A5, '0, '0);
		queue_item(KIND_WRITE, RIDX_INIT, 32'd2, '0, '0);
		queue_item(KIND_READ, RIDX_INIT, '0, '0, '0);
		queue_item(KIND_WRITE, RIDX_SPARE7, 32'd1, '0, '0);
		queue_item(KIND_READ, RIDX_SPARE6, '1, '1, '1);
		queue_item(KIND_READ, RIDX_SPARE7, '0, '0, '0);
		queue_item(KIND_WRITE, RIDX_BUFSIZE, '1, '0, '0);
		queue_item(KIND_WRITE, RIDX_INIT, 32'd1, '0, '0);
		queue_item(KIND_READ, RIDX_INIT, '0, '0, '0);
		queue_item(KIND_READ, RIDX_BUFSIZE, '0, '0, '0);
		queue_item(KIND_READ, RIDX_COUNT, '0, '0, '0);
		queue_item(KIND_PULL, RIDX_COUNT, '0, '0, '0);
		queue_item(KIND_BUFWR, RIDX_RATE, '0, 16'h0000, 8'hFF);
		queue_item(KIND_BUFWR, RIDX_RATE, '0, 16'hFFFF, 8'h5A);
		queue_item(KIND_BUFWR, RIDX_RATE, '0, 16'h0001, 8'h00);
		queue_item(KIND_WRITE, RIDX_COUNT, 32'd2, '0, '0);
		queue_item(KIND_PULL, RIDX_RATE, '0, '0, '0);
		queue_item(KIND_PULL, RIDX_RATE, '0, '0, '0);
		queue_item(KIND_PULL, RIDX_RATE, '0, '0, '0);
		queue_item(KIND_READ, RIDX_COUNT, '0, '0, '0);
		queue_item(KIND_READ, RIDX_RATE, '0, '0, '0);
		queue_item(KIND_WRITE, RIDX_COUNT, '1, '0, '0);
		queue_item(KIND_WRITE, RIDX_INIT, 32'd1, '0, '0);
		queue_item(KIND_READ, RIDX_COUNT, '0, '0, '0);

		base = bus_items.size();
		while (bus_items.size() - base < N_RANDOM) begin
			if (cur_idle_pct == 11 && bus_items.size() - base >= N_RANDOM / 3) begin
				cur_idle_pct = 65;
				drain_next = 1'b1;
			end else if (cur_idle_pct == 65 && bus_items.size() - base >= 2 * N_RANDOM / 3) begin
				cur_idle_pct = 0;
				drain_next = 1'b1;
			end
			if ($urandom_range(59) == 0)
				drain_next = 1'b1;
			if ($urandom_range(99) < 70) begin
				if (!plan_state.started || $urandom_range(15) == 0)
					queue_item(KIND_WRITE, RIDX_INIT, 32'd1, 16'($urandom), 8'($urandom));
				n = $urandom_range(1, 24);
				for (int k = 0; k < n; k++)
					queue_item(KIND_BUFWR, 3'($urandom), $urandom,
						16'(int'(plan_state.rd_pos) + k), 8'($urandom));
				case ($urandom_range(19))
					0:       wd = $urandom;
					1:       wd = '1;
					2:       wd = '0;
					default: wd = 32'(n);
				endcase
				queue_item(KIND_WRITE, RIDX_COUNT, wd, 16'($urandom), 8'($urandom));
				extra = $urandom_range(3);
				for (int k = 0; k < n + extra; k++) begin
					if ($urandom_range(99) < 15)
						queue_item(KIND_READ, 3'($urandom), $urandom, 16'($urandom),
							8'($urandom));
					queue_item(KIND_PULL, 3'($urandom), $urandom, 16'($urandom),
						8'($urandom));
				end
			end else begin
				case ($urandom_range(3))
					0:       wd = '0;
					1:       wd = '1;
					2:       wd = 32'd1;
					default: wd = $urandom;
				endcase
				queue_item(2'($urandom), 3'($urandom), wd, 16'($urandom), 8'($urandom));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (bus_items.size() != 0 || start || items_sent != results_seen);
		repeat (8) @(posedge clk);
		if (expected_responses.size() != 0) begin
			$error("%0d expected results never arrived", expected_responses.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("tb_audio_ring_buffer_device: PASS");
		end else begin
			$display("tb_audio_ring_buffer_device: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("tb_audio_ring_buffer_device: FAIL");
		$finish;
	end

endmodule

[audio_ring_buffer_device.f]
hdl/arb_pkg.sv
hdl/arb_ram.sv
hdl/arb_front.sv
hdl/arb_back.sv
hdl/audio_ring_buffer_device.sv
hdl/arb_checker.sv
verif/tb_audio_ring_buffer_device.sv
